FILE: src/nfcfe_pkg.sv
// shared types, register map, command codes and reset values of the nfc front end registers
package nfcfe_pkg;

    localparam int FIFO_DEPTH_DEF = 64;
    localparam int MEM_LEN        = 25;
    localparam int CTRL_PUSH_LEN  = 10;

    localparam logic [5:0] A_COMMAND    = 6'h01;
    localparam logic [5:0] A_COMIRQ     = 6'h04;
    localparam logic [5:0] A_DIVIRQ     = 6'h05;
    localparam logic [5:0] A_ERROR      = 6'h06;
    localparam logic [5:0] A_STATUS1    = 6'h07;
    localparam logic [5:0] A_STATUS2    = 6'h08;
    localparam logic [5:0] A_FIFODATA   = 6'h09;
    localparam logic [5:0] A_FIFOLEVEL  = 6'h0A;
    localparam logic [5:0] A_CONTROL    = 6'h0C;
    localparam logic [5:0] A_BITFRAMING = 6'h0D;
    localparam logic [5:0] A_MODE       = 6'h11;
    localparam logic [5:0] A_TXCONTROL  = 6'h14;
    localparam logic [5:0] A_CRCMSB     = 6'h21;
    localparam logic [5:0] A_CRCLSB     = 6'h22;

    localparam logic [3:0] CMD_HALT     = 4'h0;
    localparam logic [3:0] CMD_MEM      = 4'h1;
    localparam logic [3:0] CMD_RANDID   = 4'h2;
    localparam logic [3:0] CMD_CRC      = 4'h3;
    localparam logic [3:0] CMD_SEND     = 4'h4;
    localparam logic [3:0] CMD_NOCHANGE = 4'h7;
    localparam logic [3:0] CMD_RECV     = 4'h8;
    localparam logic [3:0] CMD_XCHG     = 4'hC;
    localparam logic [3:0] CMD_RESET    = 4'hF;

    localparam logic [5:0] COMMAND_RST = 6'h20;
    localparam logic [7:0] MODE_RST    = 8'h3F;
    localparam logic [7:0] TXCTL_RST   = 8'h80;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_LATCH,
        DP_WRITE,
        DP_RDCAP,
        DP_PUSH,
        DP_POPWR,
        DP_CRCSTEP,
        DP_CRCDONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   walk;
    } dp_cmd_t;

    typedef struct packed {
        logic       pend;
        logic [5:0] addr;
        logic [7:0] byte_val;
        logic [3:0] code;
        logic       cnt_zero;
        logic       push_last;
        logic       pop_done;
        logic       crc_last;
    } dp_stat_t;

    // power-up value of a register kept in the register memory
    function automatic logic [7:0] reg_default(input logic [5:0] a);
        logic [7:0] v;
        unique case (a)
            6'h15:   v = 8'h40;
            6'h18:   v = 8'h84;
            6'h19:   v = 8'h4D;
            6'h1F:   v = 8'hEB;
            6'h26:   v = 8'h48;
            6'h27:   v = 8'h88;
            6'h37:   v = 8'h82;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_preset(input logic [1:0] sel);
        logic [15:0] v;
        unique case (sel)
            2'd0:    v = 16'h0000;
            2'd1:    v = 16'h6363;
            2'd2:    v = 16'hA671;
            default: v = 16'hFFFF;
        endcase
        return v;
    endfunction

endpackage

FILE: src/nfcfe_ctrl.sv
// controller state machine of the nfc front end registers
module nfcfe_ctrl
    import nfcfe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DECODE  = 11'b000_0000_0010,
        S_RDCAP   = 11'b000_0000_0100,
        S_PUSH    = 11'b000_0000_1000,
        S_POPRD   = 11'b000_0001_0000,
        S_POPWR   = 11'b000_0010_0000,
        S_CRCRD   = 11'b000_0100_0000,
        S_CRCSTEP = 11'b000_1000_0000,
        S_CRCDONE = 11'b001_0000_0000,
        S_OUT     = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_NONE;
        cmd.walk   = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = DP_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.pend) begin
                    cmd.op     = DP_WRITE;
                    state_next = S_OUT;
                    if (stat.addr == A_COMMAND) begin
                        if (stat.code == CMD_MEM) begin
                            state_next = stat.cnt_zero ? S_PUSH : S_POPRD;
                        end else if (stat.code == CMD_CRC) begin
                            state_next = stat.cnt_zero ? S_CRCDONE : S_CRCRD;
                        end
                    end else if (stat.addr == A_CONTROL && stat.byte_val[5]) begin
                        state_next = S_PUSH;
                    end
                end else if (stat.byte_val[7]) begin
                    state_next = S_RDCAP;
                end else begin
                    cmd.op     = DP_LATCH;
                    state_next = S_IDLE;
                end
            end
            S_RDCAP: begin
                cmd.op     = DP_RDCAP;
                state_next = S_OUT;
            end
            S_PUSH: begin
                cmd.op = DP_PUSH;
                if (stat.push_last) begin
                    state_next = S_OUT;
                end
            end
            S_POPRD: begin
                state_next = stat.pop_done ? S_OUT : S_POPWR;
            end
            S_POPWR: begin
                cmd.op     = DP_POPWR;
                state_next = S_POPRD;
            end
            S_CRCRD: begin
                cmd.walk   = 1'b1;
                state_next = S_CRCSTEP;
            end
            S_CRCSTEP: begin
                cmd.op     = DP_CRCSTEP;
                cmd.walk   = 1'b1;
                state_next = stat.crc_last ? S_CRCDONE : S_CRCRD;
            end
            S_CRCDONE: begin
                cmd.op     = DP_CRCDONE;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/nfcfe_dp.sv
// datapath of the nfc front end registers: register file, fifo, memory buffer, crc
module nfcfe_dp
    import nfcfe_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] host_byte,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic [7:0] reply_byte
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam int IW = (CW > 5) ? CW : 5;
    localparam logic [PW-1:0] PMAX  = PW'(FIFO_DEPTH - 1);
    localparam logic [TW-1:0] DEPTH_T = TW'(FIFO_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

    logic [7:0]    byte_reg, byte_next;
    logic          pend_reg, pend_next;
    logic [5:0]    paddr_reg, paddr_next;
    logic [7:0]    reply_reg, reply_next;
    logic [5:0]    cmdr_reg, cmdr_next;
    logic [6:0]    comirq_reg, comirq_next;
    logic [6:0]    divirq_reg, divirq_next;
    logic          ovfl_reg, ovfl_next;
    logic [4:0]    ctrl_reg, ctrl_next;
    logic [7:0]    mode_reg, mode_next;
    logic [7:0]    txctl_reg, txctl_next;
    logic [7:0]    crcmsb_reg, crcmsb_next;
    logic [7:0]    crclsb_reg, crclsb_next;
    logic [PW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [4:0]    plen_reg, plen_next;
    logic [15:0]   crc_reg, crc_next;
    logic [63:0]   vld_reg, vld_next;

    logic [7:0]    fifo_mem [FIFO_DEPTH];
    logic [7:0]    fifo_rd_reg;
    logic [7:0]    reg_mem [64];
    logic [7:0]    reg_rd_reg;
    logic [7:0]    mbuf_reg [MEM_LEN];

    logic          fifo_we;
    logic [PW-1:0] fifo_wa;
    logic [7:0]    fifo_wd;
    logic          rm_we;
    logic [7:0]    rm_wd;
    logic          mb_we;
    logic [7:0]    mb_wd;
    logic          push_req;
    logic [7:0]    push_val;
    logic          pop_req;
    logic [TW-1:0] tail_sum;
    logic [PW-1:0] tail;
    logic [3:0]    code_eff;
    logic [31:0]   cnt32;
    logic [7:0]    ch;
    logic [15:0]   crc_step;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PMAX) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        tail_sum = TW'(head_reg) + TW'(cnt_reg);
        if (tail_sum >= DEPTH_T) begin
            tail_sum = tail_sum - DEPTH_T;
        end
        tail = tail_sum[PW-1:0];
    end

    assign code_eff = (byte_reg[3:0] == CMD_NOCHANGE) ? cmdr_reg[3:0] : byte_reg[3:0];
    assign cnt32    = 32'(cnt_reg);

    // iso14443 crc, one byte
    always_comb begin
        ch       = fifo_rd_reg ^ crc_reg[7:0];
        ch       = ch ^ {ch[3:0], 4'b0000};
        crc_step = {8'h00, crc_reg[15:8]} ^ {ch, 8'h00} ^ {5'b0, ch, 3'b000}
                   ^ {12'h000, ch[7:4]};
    end

    always_comb begin
        byte_next   = byte_reg;
        pend_next   = pend_reg;
        paddr_next  = paddr_reg;
        reply_next  = reply_reg;
        cmdr_next   = cmdr_reg;
        comirq_next = comirq_reg;
        divirq_next = divirq_reg;
        ovfl_next   = ovfl_reg;
        ctrl_next   = ctrl_reg;
        mode_next   = mode_reg;
        txctl_next  = txctl_reg;
        crcmsb_next = crcmsb_reg;
        crclsb_next = crclsb_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        wptr_next   = wptr_reg;
        idx_next    = idx_reg;
        plen_next   = plen_reg;
        crc_next    = crc_reg;
        vld_next    = vld_reg;
        rm_we       = 1'b0;
        rm_wd       = byte_reg;
        mb_we       = 1'b0;
        mb_wd       = fifo_rd_reg;
        push_req    = 1'b0;
        push_val    = byte_reg;
        pop_req     = 1'b0;

        case (cmd.op)
            DP_ACCEPT: begin
                byte_next = host_byte;
            end
            DP_LATCH: begin
                pend_next  = 1'b1;
                paddr_next = byte_reg[5:0];
            end
            DP_WRITE: begin
                pend_next  = 1'b0;
                reply_next = {2'b00, paddr_reg};
                idx_next   = '0;
                wptr_next  = head_reg;
                crc_next   = crc_preset(mode_reg[1:0]);
                plen_next  = 5'(MEM_LEN - 1);
                unique case (paddr_reg)
                    A_COMMAND: begin
                        unique case (code_eff)
                            CMD_MEM, CMD_RANDID: begin
                                cmdr_next = {byte_reg[5:4], CMD_HALT};
                            end
                            CMD_SEND: begin
                                cnt_next    = '0;
                                comirq_next = comirq_reg | 7'h50;
                                cmdr_next   = {byte_reg[5:4], CMD_HALT};
                            end
                            CMD_RESET: begin
                                cmdr_next   = COMMAND_RST;
                                comirq_next = '0;
                                divirq_next = '0;
                                ovfl_next   = 1'b0;
                                ctrl_next   = '0;
                                mode_next   = MODE_RST;
                                txctl_next  = TXCTL_RST;
                                crcmsb_next = '0;
                                crclsb_next = '0;
                                cnt_next    = '0;
                                vld_next    = '0;
                            end
                            default: begin
                                cmdr_next = {byte_reg[5:4], code_eff};
                            end
                        endcase
                    end
                    A_COMIRQ: begin
                        comirq_next = byte_reg[7] ? (comirq_reg | byte_reg[6:0])
                                                  : (comirq_reg & ~byte_reg[6:0]);
                    end
                    A_DIVIRQ: begin
                        divirq_next = byte_reg[7] ? (divirq_reg | byte_reg[6:0])
                                                  : (divirq_reg & ~byte_reg[6:0]);
                    end
                    A_ERROR, A_STATUS1, A_STATUS2: begin
                    end
                    A_FIFODATA: begin
                        push_req = 1'b1;
                    end
                    A_FIFOLEVEL: begin
                        if (byte_reg[7]) begin
                            cnt_next  = '0;
                            ovfl_next = 1'b0;
                        end
                    end
                    A_CONTROL: begin
                        if (byte_reg[6]) begin
                            comirq_next[0] = 1'b1;
                        end
                        ctrl_next = byte_reg[4:0];
                        plen_next = 5'(CTRL_PUSH_LEN - 1);
                    end
                    A_BITFRAMING: begin
                        rm_we              = 1'b1;
                        rm_wd              = {1'b0, byte_reg[6:0]};
                        vld_next[paddr_reg] = 1'b1;
                        if (byte_reg[7] && cmdr_reg[3:0] == CMD_XCHG) begin
                            cnt_next = '0;
                            if (txctl_reg[1:0] != 2'b00) begin
                                comirq_next[6] = 1'b1;
                            end
                        end
                    end
                    A_MODE:      mode_next   = byte_reg;
                    A_TXCONTROL: txctl_next  = byte_reg;
                    A_CRCMSB:    crcmsb_next = byte_reg;
                    A_CRCLSB:    crclsb_next = byte_reg;
                    default: begin
                        rm_we               = 1'b1;
                        vld_next[paddr_reg] = 1'b1;
                    end
                endcase
            end
            DP_RDCAP: begin
                unique case (byte_reg[5:0])
                    A_FIFODATA: begin
                        reply_next = (cnt_reg == '0) ? 8'h00 : fifo_rd_reg;
                        pop_req    = (cnt_reg != '0);
                    end
                    A_FIFOLEVEL: reply_next = (cnt32 > 32'd255) ? 8'hFF : cnt32[7:0];
                    A_STATUS1: begin
                        reply_next = (crcmsb_reg == '0 && crclsb_reg == '0) ? 8'h60 : 8'h20;
                    end
                    A_STATUS2: begin
                        reply_next = (cmdr_reg[3:0] == CMD_XCHG ||
                                      cmdr_reg[3:0] == CMD_RECV) ? 8'h05 : 8'h00;
                    end
                    A_COMMAND:   reply_next = {2'b00, cmdr_reg};
                    A_COMIRQ:    reply_next = {1'b0, comirq_reg};
                    A_DIVIRQ:    reply_next = {1'b0, divirq_reg};
                    A_ERROR:     reply_next = {3'b000, ovfl_reg, 4'h0};
                    A_CONTROL:   reply_next = {3'b000, ctrl_reg};
                    A_MODE:      reply_next = mode_reg;
                    A_TXCONTROL: reply_next = txctl_reg;
                    A_CRCMSB:    reply_next = crcmsb_reg;
                    A_CRCLSB:    reply_next = crclsb_reg;
                    default: begin
                        reply_next = vld_reg[byte_reg[5:0]] ? reg_rd_reg
                                                           : reg_default(byte_reg[5:0]);
                    end
                endcase
            end
            DP_PUSH: begin
                push_req = 1'b1;
                push_val = mbuf_reg[idx_reg[4:0]];
                idx_next = idx_reg + 1'b1;
            end
            DP_POPWR: begin
                mb_we    = 1'b1;
                pop_req  = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            DP_CRCSTEP: begin
                crc_next  = crc_step;
                wptr_next = ptr_inc(wptr_reg);
                idx_next  = idx_reg + 1'b1;
            end
            DP_CRCDONE: begin
                crcmsb_next    = crc_reg[15:8];
                crclsb_next    = crc_reg[7:0];
                cnt_next       = '0;
                divirq_next[2] = 1'b1;
            end
            default: begin
            end
        endcase

        // fifo write side, overflow drops the beat
        fifo_we = 1'b0;
        fifo_wa = tail;
        fifo_wd = push_val;
        if (push_req) begin
            if (cnt_reg < DEPTH_C) begin
                fifo_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end else begin
                ovfl_next = 1'b1;
            end
        end
        if (pop_req) begin
            head_next = ptr_inc(head_reg);
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[fifo_wa] <= fifo_wd;
        end
        fifo_rd_reg <= fifo_mem[cmd.walk ? wptr_reg : head_reg];
    end

    always_ff @(posedge aclk) begin
        if (rm_we) begin
            reg_mem[paddr_reg] <= rm_wd;
        end
        reg_rd_reg <= reg_mem[byte_reg[5:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MEM_LEN; i++) begin
                mbuf_reg[i] <= '0;
            end
        end else if (mb_we) begin
            mbuf_reg[idx_reg[4:0]] <= mb_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            paddr_reg  <= '0;
            cmdr_reg   <= COMMAND_RST;
            comirq_reg <= '0;
            divirq_reg <= '0;
            ovfl_reg   <= 1'b0;
            ctrl_reg   <= '0;
            mode_reg   <= MODE_RST;
            txctl_reg  <= TXCTL_RST;
            crcmsb_reg <= '0;
            crclsb_reg <= '0;
            head_reg   <= '0;
            cnt_reg    <= '0;
            vld_reg    <= '0;
        end else begin
            pend_reg   <= pend_next;
            paddr_reg  <= paddr_next;
            cmdr_reg   <= cmdr_next;
            comirq_reg <= comirq_next;
            divirq_reg <= divirq_next;
            ovfl_reg   <= ovfl_next;
            ctrl_reg   <= ctrl_next;
            mode_reg   <= mode_next;
            txctl_reg  <= txctl_next;
            crcmsb_reg <= crcmsb_next;
            crclsb_reg <= crclsb_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        reply_reg <= reply_next;
        wptr_reg  <= wptr_next;
        idx_reg   <= idx_next;
        plen_reg  <= plen_next;
        crc_reg   <= crc_next;
    end

    assign stat.pend      = pend_reg;
    assign stat.addr      = paddr_reg;
    assign stat.byte_val  = byte_reg;
    assign stat.code      = code_eff;
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.push_last = (idx_reg[4:0] == plen_reg);
    assign stat.pop_done  = (idx_reg == IW'(MEM_LEN)) || (cnt_reg == '0);
    assign stat.crc_last  = (idx_reg == IW'(cnt_reg) - 1'b1);
    assign reply_byte     = reply_reg;

endmodule

FILE: src/nfc_frontend_register_unit.sv
// top level of the nfc front end host register unit
// a read beat passes the decode, read capture and reply states; a data write beat passes decode and reply
// command/control writes add a walk before the reply: mem push, control push, mem pop
//   (fifo to memory buffer) or calccrc over the fifo bytes (single-port fifo read)
// one beat in flight; next beat taken after decode of an address beat, else after the reply
// sync reset restores power-up values, empties fifo, clears memory buffer (softreset keeps it)
module nfc_frontend_register_unit
    import nfcfe_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_host_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_reply_byte
);

    // command and status between the sequencer and the datapath
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer: decode of the host beat, mem/crc walks, reply handshake
    nfcfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // storage: register file, byte fifo, memory buffer, crc engine
    nfcfe_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .host_byte  (s_host_byte),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .reply_byte (m_reply_byte)
    );

endmodule
